>>> hw/rtl/rpce_pkg.sv
// Shared widths, constants and controller/datapath interface types for the estimator.
package rpce_pkg;

    // Field and storage widths.
    localparam int SAMPLE_W    = 16;
    localparam int SUM_W       = 25;
    localparam int MAG_W       = 24;
    localparam int SQ_W        = 48;
    localparam int Q_W         = 16;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;

    // Frame geometry limits.
    localparam int MAX_READOUT  = 4096;
    localparam int MAX_CHANNELS = 64;
    localparam int MAX_LINES    = 256;
    localparam int RO_W = $clog2(MAX_READOUT);
    localparam int CH_W = $clog2(MAX_CHANNELS);
    localparam int LN_W = $clog2(MAX_LINES);

    // Iteration counts of the shared arithmetic steps.
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int DIV_STEPS  = Q_W;
    localparam int CNT_W      = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINES    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic accumulate;
        logic square_re;
        logic square_im;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic div_first;
        logic load_out;
    } rpce_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic produce;
        logic out_busy;
    } rpce_status_t;

endpackage

>>> hw/rtl/rpce_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/rpce_datapath.sv
// Datapath: configuration, positions, sum store, squarer, square root and dividers.
module rpce_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rpce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rpce_pkg::CFG_W-1:0]       cfg_data,
    input  logic signed [rpce_pkg::SAMPLE_W-1:0] sample_real,
    input  logic signed [rpce_pkg::SAMPLE_W-1:0] sample_imag,
    input  rpce_pkg::rpce_cmd_t              cmd,
    output rpce_pkg::rpce_status_t           status,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic signed [rpce_pkg::Q_W-1:0]  correction_real,
    output logic signed [rpce_pkg::Q_W-1:0]  correction_imag,
    output logic                             last_of_frame
);
    import rpce_pkg::*;

    // Counts stored as count minus one, already clamped.
    logic [CH_W-1:0] ch_last_reg;
    logic [RO_W-1:0] ro_last_reg;
    logic [LN_W-1:0] ln_last_reg;
    logic [CH_W-1:0] ch_pos_reg;
    logic [RO_W-1:0] ro_pos_reg;
    logic [LN_W-1:0] ln_pos_reg;
    logic            last_reg;

    logic signed [SAMPLE_W-1:0] smp_re_reg, smp_im_reg;
    logic signed [SUM_W-1:0]    sum_re_reg, sum_im_reg;
    logic signed [SUM_W-1:0]    sum_re_next, sum_im_next;
    logic [2*SUM_W-1:0]         rd_data;

    logic [SQ_W-1:0] sq_reg, x_reg, res_reg, bit_reg;
    logic [MAG_W-1:0] mag_reg, ar_reg, ai_reg;
    logic [MAG_W-1:0] abs_re, abs_im;
    logic            neg_re_reg, neg_im_reg;
    logic [Q_W-1:0]  qr_reg, qi_reg;

    logic            out_valid_reg;
    logic signed [Q_W-1:0] corr_re_reg, corr_im_reg;
    logic            out_last_reg;

    logic [SUM_W-1:0] neg_sum_re, neg_sum_im;
    logic [SQ_W-1:0]  sqrt_t;
    logic [MAG_W:0]   div_tr, div_ti;
    logic [Q_W-1:0]   sat_r, sat_i;

    // Clamp a written count to its range and keep it as count minus one.
    function automatic logic [RO_W:0] clamp_last(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] max);
        logic [CFG_W-1:0] c;
        begin
            c = v;
            if (v == '0)
            begin
                c = CFG_W'(1);
            end
            else if (v > max)
            begin
                c = max;
            end
            clamp_last = (RO_W+1)'(c - CFG_W'(1));
        end
    endfunction

    // Sum store: one entry per readout position, real sum in the upper half.
    rpce_ram #(
        .WIDTH(2*SUM_W),
        .DEPTH(MAX_READOUT)
    ) u_sum_ram (
        .clk  (clk),
        .we   (cmd.accumulate),
        .waddr(ro_pos_reg),
        .wdata({sum_re_next, sum_im_next}),
        .re   (cmd.capture),
        .raddr(ro_pos_reg),
        .rdata(rd_data)
    );

    // New sum: line zero starts over, later lines add to the stored sum.
    always_comb
    begin
        if (ln_pos_reg == '0)
        begin
            sum_re_next = SUM_W'(smp_re_reg);
            sum_im_next = SUM_W'(smp_im_reg);
        end
        else
        begin
            sum_re_next = $signed(rd_data[2*SUM_W-1:SUM_W]) + SUM_W'(smp_re_reg);
            sum_im_next = $signed(rd_data[SUM_W-1:0]) + SUM_W'(smp_im_reg);
        end
    end

    // Magnitudes of the stored sums.
    assign neg_sum_re = -sum_re_reg;
    assign neg_sum_im = -sum_im_reg;
    assign abs_re = sum_re_reg[SUM_W-1] ? neg_sum_re[MAG_W-1:0] : sum_re_reg[MAG_W-1:0];
    assign abs_im = sum_im_reg[SUM_W-1] ? neg_sum_im[MAG_W-1:0] : sum_im_reg[MAG_W-1:0];

    // One square-root digit and one quotient bit per step.
    assign sqrt_t = res_reg + bit_reg;
    assign div_tr = cmd.div_first ? {1'b0, ar_reg} : {ar_reg, 1'b0};
    assign div_ti = cmd.div_first ? {1'b0, ai_reg} : {ai_reg, 1'b0};

    // Saturate quotients to 32767.
    assign sat_r = qr_reg[Q_W-1] ? {1'b0, {(Q_W-1){1'b1}}} : qr_reg;
    assign sat_i = qi_reg[Q_W-1] ? {1'b0, {(Q_W-1){1'b1}}} : qi_reg;

    assign status.produce  = (ln_pos_reg == ln_last_reg);
    assign status.out_busy = out_valid_reg && !out_ready;

    // Control registers: configuration, positions and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_last_reg   <= '0;
            ro_last_reg   <= '0;
            ln_last_reg   <= '0;
            ch_pos_reg    <= '0;
            ro_pos_reg    <= '0;
            ln_pos_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_CHANNELS || cfg_index == REG_READOUT
                           || cfg_index == REG_LINES))
            begin
                ch_pos_reg <= '0;
                ro_pos_reg <= '0;
                ln_pos_reg <= '0;
                unique case (cfg_index)
                    REG_CHANNELS: ch_last_reg <= CH_W'(clamp_last(
                        {{(CFG_W-7){1'b0}}, cfg_data[6:0]}, CFG_W'(MAX_CHANNELS)));
                    REG_READOUT:  ro_last_reg <= RO_W'(clamp_last(
                        cfg_data, CFG_W'(MAX_READOUT)));
                    REG_LINES:    ln_last_reg <= LN_W'(clamp_last(
                        {{(CFG_W-9){1'b0}}, cfg_data[8:0]}, CFG_W'(MAX_LINES)));
                    default: ;
                endcase
            end
            else if (cmd.accumulate)
            begin
                if (ro_pos_reg == ro_last_reg)
                begin
                    ro_pos_reg <= '0;
                    if (ln_pos_reg == ln_last_reg)
                    begin
                        ln_pos_reg <= '0;
                        ch_pos_reg <= (ch_pos_reg == ch_last_reg) ? '0
                                                                  : ch_pos_reg + CH_W'(1);
                    end
                    else
                    begin
                        ln_pos_reg <= ln_pos_reg + LN_W'(1);
                    end
                end
                else
                begin
                    ro_pos_reg <= ro_pos_reg + RO_W'(1);
                end
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Arithmetic payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            smp_re_reg <= sample_real;
            smp_im_reg <= sample_imag;
        end
        if (cmd.accumulate)
        begin
            sum_re_reg <= sum_re_next;
            sum_im_reg <= sum_im_next;
            last_reg   <= (ro_pos_reg == ro_last_reg) && (ch_pos_reg == ch_last_reg);
        end
        if (cmd.square_re)
        begin
            sq_reg <= abs_re * abs_re;
        end
        if (cmd.square_im)
        begin
            x_reg   <= sq_reg + abs_im * abs_im;
            res_reg <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end
        if (cmd.sqrt_step)
        begin
            if (x_reg >= sqrt_t)
            begin
                x_reg   <= x_reg - sqrt_t;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_init)
        begin
            mag_reg    <= res_reg[MAG_W-1:0];
            ar_reg     <= abs_re;
            ai_reg     <= abs_im;
            neg_re_reg <= sum_re_reg[SUM_W-1];
            neg_im_reg <= !sum_im_reg[SUM_W-1] && (sum_im_reg != '0);
            qr_reg     <= '0;
            qi_reg     <= '0;
        end
        if (cmd.div_step)
        begin
            if (div_tr >= {1'b0, mag_reg})
            begin
                ar_reg <= MAG_W'(div_tr - {1'b0, mag_reg});
                qr_reg <= {qr_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                ar_reg <= div_tr[MAG_W-1:0];
                qr_reg <= {qr_reg[Q_W-2:0], 1'b0};
            end
            if (div_ti >= {1'b0, mag_reg})
            begin
                ai_reg <= MAG_W'(div_ti - {1'b0, mag_reg});
                qi_reg <= {qi_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                ai_reg <= div_ti[MAG_W-1:0];
                qi_reg <= {qi_reg[Q_W-2:0], 1'b0};
            end
        end
        if (cmd.load_out)
        begin
            out_last_reg <= last_reg;
            if (mag_reg == '0)
            begin
                corr_re_reg <= {1'b0, {(Q_W-1){1'b1}}};
                corr_im_reg <= '0;
            end
            else
            begin
                corr_re_reg <= neg_re_reg ? -$signed(sat_r) : $signed(sat_r);
                corr_im_reg <= neg_im_reg ? -$signed(sat_i) : $signed(sat_i);
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign correction_real = corr_re_reg;
    assign correction_imag = corr_im_reg;
    assign last_of_frame   = out_last_reg;

endmodule

>>> hw/rtl/rpce_ctrl.sv
// Controller: sequences accumulation, square root, division and result loading.
module rpce_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rpce_pkg::rpce_status_t status,
    output rpce_pkg::rpce_cmd_t    cmd
);
    import rpce_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_SQ_RE,
        S_SQ_IM,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_OUT
    } state_t;

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Next state and step counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_ACC;
            S_ACC:      state_next = status.produce ? S_SQ_RE : S_IDLE;
            S_SQ_RE:    state_next = S_SQ_IM;
            S_SQ_IM:
            begin
                state_next = S_SQRT;
                cnt_next   = '0;
            end
            S_SQRT:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                state_next = S_DIV;
                cnt_next   = '0;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:      if (!status.out_busy) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Commands decoded from the state.
    always_comb
    begin
        cmd            = '0;
        cmd.capture    = (state_reg == S_IDLE) && in_valid;
        cmd.accumulate = (state_reg == S_ACC);
        cmd.square_re  = (state_reg == S_SQ_RE);
        cmd.square_im  = (state_reg == S_SQ_IM);
        cmd.sqrt_step  = (state_reg == S_SQRT);
        cmd.div_init   = (state_reg == S_DIV_INIT);
        cmd.div_step   = (state_reg == S_DIV);
        cmd.div_first  = (cnt_reg == '0);
        cmd.load_out   = (state_reg == S_OUT) && !status.out_busy;
    end

    assign in_ready = (state_reg == S_IDLE);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> hw/rtl/reference_phase_correction_estimator.sv
// Top level of the reference-line phase correction estimator.
//
//  channel   direction  handshake           payload
//  in        request in in_valid/in_ready   sample_real, sample_imag
//  out       request out out_valid/out_ready correction_real, correction_imag, last_of_frame
//  cfg       write in   cfg_we              cfg_index, cfg_data
//
// A sample that yields no correction is captured with a sum-store read, then added and written
// back. A sample of the last reference line also passes through the squarer, the bit-a-cycle
// square root and the bit-a-cycle dividers, plus any wait for the output register.
// Reset clears positions, counts (to one) and the output valid; the sum store needs no reset.
// A request is accepted while an earlier result still waits in the output register.
module reference_phase_correction_estimator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rpce_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rpce_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [rpce_pkg::SAMPLE_W-1:0] sample_real,
    input  logic signed [rpce_pkg::SAMPLE_W-1:0] sample_imag,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rpce_pkg::Q_W-1:0]      correction_real,
    output logic signed [rpce_pkg::Q_W-1:0]      correction_imag,
    output logic                                 last_of_frame
);
    import rpce_pkg::*;

    rpce_cmd_t    cmd;
    rpce_status_t status;

    // Sequencer.
    rpce_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic and storage.
    rpce_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_real    (sample_real),
        .sample_imag    (sample_imag),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .correction_real(correction_real),
        .correction_imag(correction_imag),
        .last_of_frame  (last_of_frame)
    );

endmodule

>>> hw/rtl/rpce_checker.sv
// Port-level assertions for the estimator and the bind that attaches them.
module rpce_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [rpce_pkg::Q_W-1:0]      correction_real,
    input logic signed [rpce_pkg::Q_W-1:0]      correction_imag
);
    import rpce_pkg::*;

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(correction_real)
                                    && $stable(correction_imag))
        else $error("stalled result changed");

    // One request at a time: an accepted sample drops ready in the next cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after accept");

    // Saturation never yields the most negative code.
    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> correction_real != 16'sh8000 && correction_imag != 16'sh8000)
        else $error("correction outside saturation range");

    // A unit correction never has both parts zero.
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> correction_real != 16'sh0000 || correction_imag != 16'sh0000)
        else $error("zero correction");

endmodule

bind reference_phase_correction_estimator rpce_checker u_rpce_checker (.*);

>>> test/rpce_checker.sv
`timescale 1ns / 1ps
// Checker for the phase correction estimator: predicts each correction and compares it.
module rpce_scoreboard (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rpce_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rpce_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic signed [rpce_pkg::SAMPLE_W-1:0] sample_real,
    input  logic signed [rpce_pkg::SAMPLE_W-1:0] sample_imag,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [rpce_pkg::Q_W-1:0]      correction_real,
    input  logic signed [rpce_pkg::Q_W-1:0]      correction_imag,
    input  logic                                 last_of_frame,
    output int                                   pending,
    output int                                   failures
);
    import rpce_pkg::*;

    typedef struct packed {
        logic signed [Q_W-1:0] re;
        logic signed [Q_W-1:0] im;
        logic                  last;
    } correction_t;

    correction_t awaited_corrections[$];

    // Raw register values and frame positions of the model.
    logic [6:0]  channels_reg;
    logic [12:0] readout_reg;
    logic [8:0]  lines_reg;
    int          ro_pos;
    int          ln_pos;
    int          ch_pos;
    longint      acc_re[MAX_READOUT];
    longint      acc_im[MAX_READOUT];

    assign pending = awaited_corrections.size();

    function automatic int effective_count(int raw, int limit);
        if (raw == 0)
            return 1;
        return (raw > limit) ? limit : raw;
    endfunction

    // Floored square root, two bits per step.
    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > x)
            probe = probe >> 2;
        while (probe != 0) begin
            if (x >= root + probe) begin
                x = x - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Signed ratio in Q1.15, truncated toward zero and saturated.
    function automatic logic signed [Q_W-1:0] unit_ratio(longint num, longint mag);
        longint q;
        q = (num * 32768) / mag;
        if (q > 32767)
            q = 32767;
        if (q < -32767)
            q = -32767;
        return q[Q_W-1:0];
    endfunction

    // Accumulates one sample and returns whether a correction falls due.
    function automatic bit accumulate_sample(input logic signed [SAMPLE_W-1:0] re,
                                             input logic signed [SAMPLE_W-1:0] im,
                                             output correction_t corr);
        int              nch;
        int              nro;
        int              nln;
        longint          sr;
        longint          si;
        longint unsigned mag;
        bit              due;
        nch = effective_count(channels_reg, MAX_CHANNELS);
        nro = effective_count(readout_reg, MAX_READOUT);
        nln = effective_count(lines_reg, MAX_LINES);
        if (ln_pos == 0) begin
            acc_re[ro_pos] = re;
            acc_im[ro_pos] = im;
        end
        else begin
            acc_re[ro_pos] += re;
            acc_im[ro_pos] += im;
        end
        due = (ln_pos + 1 >= nln);
        if (due) begin
            sr = acc_re[ro_pos];
            si = acc_im[ro_pos];
            mag = floor_root(sr * sr + si * si);
            if (mag == 0) begin
                corr.re = 16'sd32767;
                corr.im = 16'sd0;
            end
            else begin
                corr.re = unit_ratio(sr, mag);
                corr.im = unit_ratio(-si, mag);
            end
            corr.last = (ro_pos + 1 >= nro) && (ch_pos + 1 >= nch);
        end
        ro_pos++;
        if (ro_pos >= nro) begin
            ro_pos = 0;
            ln_pos++;
            if (ln_pos >= nln) begin
                ln_pos = 0;
                ch_pos++;
                if (ch_pos >= nch)
                    ch_pos = 0;
            end
        end
        return due;
    endfunction

    // Watch the three ports at every edge.
    always @(posedge clk or negedge rst_n)
    begin
        correction_t corr;
        correction_t head;
        if (!rst_n) begin
            channels_reg <= 7'd1;
            readout_reg <= 13'd1;
            lines_reg <= 9'd1;
            ro_pos = 0;
            ln_pos = 0;
            ch_pos = 0;
            awaited_corrections.delete();
            failures <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (awaited_corrections.size() == 0) begin
                    $display("%0t: unexpected correction re=%0d im=%0d last=%0d", $time,
                             correction_real, correction_imag, last_of_frame);
                    failures <= failures + 1;
                end
                else begin
                    head = awaited_corrections.pop_front();
                    if (head.re !== correction_real || head.im !== correction_imag
                        || head.last !== last_of_frame) begin
                        $display({"%0t: correction mismatch expected re=%0d im=%0d last=%0d,",
                                  " actual re=%0d im=%0d last=%0d"},
                                 $time, head.re, head.im, head.last,
                                 correction_real, correction_imag, last_of_frame);
                        failures <= failures + 1;
                    end
                end
            end
            if (in_valid && in_ready) begin
                if (accumulate_sample(sample_real, sample_imag, corr))
                    awaited_corrections.push_back(corr);
            end
            // Any known register write restarts the frame.
            if (cfg_we && cfg_index <= REG_LINES) begin
                case (cfg_index)
                    REG_CHANNELS: channels_reg <= cfg_data[6:0];
                    REG_READOUT:  readout_reg <= cfg_data;
                    default:      lines_reg <= cfg_data[8:0];
                endcase
                ro_pos = 0;
                ln_pos = 0;
                ch_pos = 0;
            end
        end
    end

endmodule

>>> test/tb_reference_phase_correction_estimator.sv
`timescale 1ns / 1ps
// Testbench top for the phase correction estimator: stimulus, watchdog and verdict.
module tb_reference_phase_correction_estimator;
    import rpce_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]           cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_real;
    logic signed [SAMPLE_W-1:0] sample_imag;
    logic                       out_valid;
    logic                       out_ready;
    logic signed [Q_W-1:0]      correction_real;
    logic signed [Q_W-1:0]      correction_imag;
    logic                       last_of_frame;
    int                         pending;
    int                         failures;
    bit                         steady;
    int                         quiet_cycles;
    int                         samples_sent;

    reference_phase_correction_estimator uut (.*);

    rpce_scoreboard u_scoreboard (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog on cycles with no accepted request on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[reference_phase_correction_estimator] ERROR");
            $finish;
        end
    end

    // Receiver: random stall before each correction, none while steady.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] re,
                               input logic signed [SAMPLE_W-1:0] im);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample_real <= re;
        sample_imag <= im;
        do @(posedge clk); while (!in_ready);
        samples_sent++;
    endtask

    // Drain all corrections, then give the last sample time to finish.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(input int channels, input int readout, input int lines);
        write_reg(REG_CHANNELS, channels);
        write_reg(REG_READOUT, readout);
        write_reg(REG_LINES, lines);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] draw_value(input int style);
        int pick;
        case (style)
            0: return $urandom_range(0, 65535);
            1: return $urandom_range(0, 4) - 2;
            default: begin
                pick = $urandom_range(0, 3);
                return (pick == 0) ? -16'sd32768 : (pick == 1) ? 16'sd32767
                     : (pick == 2) ? 16'sd0 : -16'sd1;
            end
        endcase
    endfunction

    task automatic random_run(input int count);
        int style;
        style = $urandom_range(0, 5);
        repeat (count)
            send_sample(draw_value(style > 2 ? 0 : style), draw_value(style > 3 ? 0 : style));
    endtask

    initial
    begin
        int k;
        int phase_len;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_real = '0;
        sample_imag = '0;
        steady = 1'b0;
        quiet_cycles = 0;
        samples_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry: every sample is its own frame.
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd1, 16'sd1);
        send_sample(16'sd3, -16'sd4);
        send_sample(-16'sd1, 16'sd0);
        settle();

        // Two lines so that opposite samples cancel to a zero sum.
        set_geometry(2, 2, 2);
        send_sample(16'sd1234, -16'sd77);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(-16'sd1234, 16'sd77);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd5, 16'sd0);
        settle();
        // A write to an index past the list must not restart the frame.
        write_reg(REG_UNUSED, 8191);
        send_sample(16'sd0, 16'sd9);
        send_sample(16'sd7, 16'sd7);
        send_sample(16'sd32767, 16'sd32767);
        settle();

        // Zero registers act as one; oversized ones as the maximum.
        set_geometry(0, 0, 0);
        send_sample(16'sd100, 16'sd200);
        settle();
        steady = 1'b1;
        set_geometry(127, 1, 1);
        random_run(70);
        settle();
        set_geometry(1, 1, 511);
        random_run(260);
        settle();
        steady = 1'b0;
        set_geometry(1, 8191, 1);
        random_run(100);
        settle();

        // Random geometries, mostly small, with partial frames.
        k = 0;
        while (k < 350) begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
                set_geometry($urandom_range(0, 127), $urandom_range(0, 8191) % 9,
                             $urandom_range(0, 511) % 5);
            else
                set_geometry($urandom_range(1, 4), $urandom_range(1, 8),
                             $urandom_range(1, 4));
            phase_len = $urandom_range(10, 60);
            random_run(phase_len);
            k += phase_len;
            settle();
        end

        if (failures == 0)
            $display("[reference_phase_correction_estimator] OK");
        else
            $display("[reference_phase_correction_estimator] ERROR");
        $finish;
    end

endmodule

>>> reference_phase_correction_estimator.f
hw/rtl/rpce_pkg.sv
hw/rtl/rpce_ram.sv
hw/rtl/rpce_datapath.sv
hw/rtl/rpce_ctrl.sv
hw/rtl/reference_phase_correction_estimator.sv
hw/rtl/rpce_checker.sv
test/rpce_checker.sv
test/tb_reference_phase_correction_estimator.sv
